[rtl/core/mahd_pkg.sv]
// ---------------------------------------------------------------------------
// mahd_pkg
// Shared types, field widths and lookup tables for the audio header decoder.
// ---------------------------------------------------------------------------
package mahd_pkg;

	localparam int BR_W   = 9;
	localparam int SR_W   = 16;
	localparam int LEN_W  = 12;
	localparam int NUM_W  = 26;
	localparam int QUO_W  = 12;
	localparam int DIV_W  = NUM_W + 2;
	localparam int DIV_STAGES = QUO_W;
	localparam int K_W    = 18;
	localparam int PROD_W = BR_W + K_W;

	localparam int FIFO_DEPTH_DEF = 4;

	localparam logic [10:0] SYNC_WORD = 11'h7FF;

	localparam logic [3:0] BRI_FREE = 4'd0;
	localparam logic [3:0] BRI_BAD  = 4'd15;

	localparam logic [1:0] VER_MPEG1 = 2'd0;
	localparam logic [1:0] LAYER_1   = 2'd0;
	localparam logic [1:0] LAYER_3   = 2'd2;
	localparam logic [1:0] MAP_RSV   = 2'd0;

	localparam logic [2:0] TBL_LSF_L1  = 3'd3;
	localparam logic [2:0] TBL_LSF_L23 = 3'd4;

	localparam logic [K_W-1:0] K_L1     = 18'd12000;
	localparam logic [K_W-1:0] K_L23    = 18'd144000;
	localparam logic [K_W-1:0] K_L3_LSF = 18'd72000;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSYNC  = 2'd1,
		ST_BADHDR  = 2'd2,
		ST_RSVRATE = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [1:0]         version;
		logic [1:0]         layer;
		logic [BR_W-1:0]    bitrate;
		logic [SR_W-1:0]    samp_freq;
		logic               padding;
		logic               crc_flag;
		logic [1:0]         chan_mode;
		logic [1:0]         mode_extension;
		logic [NUM_W-1:0]   numer;
	} mahd_item_t;

	// version id code -> 1 + version, zero when reserved
	localparam logic [1:0] VER_MAP [4] = '{2'd3, 2'd0, 2'd2, 2'd1};
	// layer code -> 1 + layer, zero when reserved
	localparam logic [1:0] LAY_MAP [4] = '{2'd0, 2'd3, 2'd2, 2'd1};

	localparam logic [BR_W-1:0] BR_TAB [5][16] = '{
		'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
		'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
		'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
		'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
		'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
	};

	localparam logic [SR_W-1:0] SR_TAB [3][4] = '{
		'{16'd44100, 16'd48000, 16'd32000, 16'd0},
		'{16'd22050, 16'd24000, 16'd16000, 16'd0},
		'{16'd11025, 16'd12000, 16'd8000,  16'd0}
	};

endpackage

[rtl/core/mpeg_audio_header_decode.sv]
// ---------------------------------------------------------------------------
// mpeg_audio_header_decode
// Audio frame header decoder: sync and code checks, table lookups and frame
// length through a decode front, a short queue and a pipelined divider.
// ---------------------------------------------------------------------------
// throughput: one header per cycle while out_ready is high, set by the
//   12-stage divider that resolves one quotient bit per stage
// reset clears the valid bits, queue pointers and queue count only; no clearing pass
// ---------------------------------------------------------------------------
module mpeg_audio_header_decode
	import mahd_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [31:0]      header_word,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [1:0]       version,
	output logic [1:0]       layer,
	output logic [BR_W-1:0]  bitrate_kbps,
	output logic [SR_W-1:0]  samp_freq_hz,
	output logic             padding,
	output logic             crc_flag,
	output logic [1:0]       chan_mode,
	output logic [1:0]       mode_extension,
	output logic [LEN_W-1:0] frame_length_bytes
);

	logic       fifo_full;
	logic       fifo_empty;
	logic       fifo_push;
	logic       fifo_pop;
	mahd_item_t push_item;
	mahd_item_t head_item;
	mahd_item_t res_item;

	mahd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.header_word (header_word),
		.q_full      (fifo_full),
		.q_push      (fifo_push),
		.q_item      (push_item)
	);

	mahd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_item (push_item),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.head_item (head_item),
		.empty     (fifo_empty)
	);

	mahd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.head_vld  (!fifo_empty),
		.pop       (fifo_pop),
		.out_item  (res_item),
		.out_len   (frame_length_bytes),
		.out_vld   (out_valid),
		.out_rdy   (out_ready)
	);

	assign status         = res_item.status;
	assign version        = res_item.version;
	assign layer          = res_item.layer;
	assign bitrate_kbps   = res_item.bitrate;
	assign samp_freq_hz   = res_item.samp_freq;
	assign padding        = res_item.padding;
	assign crc_flag       = res_item.crc_flag;
	assign chan_mode      = res_item.chan_mode;
	assign mode_extension = res_item.mode_extension;

	a_err_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> frame_length_bytes == '0)
		else $error("frame length nonzero on error status");

	a_nosync_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOSYNC |-> bitrate_kbps == '0 && version == '0)
		else $error("fields not cleared on missing sync");

	a_ok_rates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> bitrate_kbps != '0 && samp_freq_hz != '0)
		else $error("zero rate on ok status");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> fifo_full)
		else $error("input stalled while queue has room");

endmodule

[rtl/core/mahd_front.sv]
// ---------------------------------------------------------------------------
// mahd_front
// Accepts header beats, checks sync and reserved codes, looks up bitrate and
// sample rate and forms the frame length numerator into a register stage.
// ---------------------------------------------------------------------------
module mahd_front
	import mahd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] header_word,
	input  logic        q_full,
	output logic        q_push,
	output mahd_item_t  q_item
);

	logic       hdr_vld_s1;
	mahd_item_t item_s1;
	mahd_item_t dec_item;

	assign in_ready = !hdr_vld_s1 || !q_full;
	assign q_push   = hdr_vld_s1 && !q_full;
	assign q_item   = item_s1;

	always_comb begin
		logic [1:0]        vmap;
		logic [1:0]        lmap;
		logic [3:0]        bri;
		logic [1:0]        ver;
		logic [1:0]        lay;
		logic [2:0]        tbl;
		logic [BR_W-1:0]   br;
		logic [SR_W-1:0]   sr;
		logic [K_W-1:0]    kc;
		logic [PROD_W-1:0] prod;
		vmap = VER_MAP[header_word[20:19]];
		lmap = LAY_MAP[header_word[18:17]];
		bri  = header_word[15:12];
		ver  = vmap - 2'd1;
		lay  = lmap - 2'd1;
		if (ver == VER_MPEG1) begin
			tbl = {1'b0, lay};
		end else if (lay == LAYER_1) begin
			tbl = TBL_LSF_L1;
		end else begin
			tbl = TBL_LSF_L23;
		end
		br = BR_TAB[tbl][bri];
		sr = SR_TAB[ver][header_word[11:10]];
		if (lay == LAYER_1) begin
			kc = K_L1;
		end else if (lay == LAYER_3 && ver != VER_MPEG1) begin
			kc = K_L3_LSF;
		end else begin
			kc = K_L23;
		end
		prod = PROD_W'(br) * PROD_W'(kc);
		dec_item = '0;
		priority if (header_word[31:21] != SYNC_WORD) begin
			dec_item.status = ST_NOSYNC;
		end else if (bri == BRI_FREE || bri == BRI_BAD || vmap == MAP_RSV ||
				lmap == MAP_RSV) begin
			dec_item.status = ST_BADHDR;
		end else begin
			dec_item.status         = (sr == '0) ? ST_RSVRATE : ST_OK;
			dec_item.version        = ver;
			dec_item.layer          = lay;
			dec_item.bitrate        = br;
			dec_item.samp_freq      = sr;
			dec_item.padding        = header_word[9];
			dec_item.crc_flag       = header_word[16];
			dec_item.chan_mode      = header_word[7:6];
			dec_item.mode_extension = header_word[5:4];
			dec_item.numer          = prod[NUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			hdr_vld_s1 <= 1'b1;
		end else if (q_push) begin
			hdr_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= dec_item;
		end
	end

endmodule

[rtl/core/mahd_fifo.sv]
// ---------------------------------------------------------------------------
// mahd_fifo
// Short queue of decoded headers between the decode front and the divider.
// ---------------------------------------------------------------------------
module mahd_fifo
	import mahd_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mahd_item_t push_item,
	output logic       full,
	input  logic       pop,
	output mahd_item_t head_item,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mahd_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/core/mahd_back.sv]
// ---------------------------------------------------------------------------
// mahd_back
// Restoring divider pipeline, one quotient bit per stage, then the padding
// and layer scaling into the output register.
// ---------------------------------------------------------------------------
module mahd_back
	import mahd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mahd_item_t       head_item,
	input  logic             head_vld,
	output logic             pop,
	output mahd_item_t       out_item,
	output logic [LEN_W-1:0] out_len,
	output logic             out_vld,
	input  logic             out_rdy
);

	logic                  adv;
	logic                  vld_s  [DIV_STAGES];
	mahd_item_t            item_s [DIV_STAGES];
	logic [NUM_W-1:0]      rem_s  [DIV_STAGES];
	logic [QUO_W-1:0]      quo_s  [DIV_STAGES];

	mahd_item_t            st_item [DIV_STAGES+1];
	logic [NUM_W-1:0]      st_rem  [DIV_STAGES+1];
	logic [QUO_W-1:0]      st_quo  [DIV_STAGES+1];
	logic [DIV_STAGES:0]   st_vld;

	logic                  out_vld_q;
	mahd_item_t            out_item_q;
	logic [LEN_W-1:0]      out_len_q;
	logic [LEN_W:0]        len_sum;
	logic [LEN_W-1:0]      len_val;

	assign adv = !out_vld_q || out_rdy;
	assign pop = adv && head_vld;

	assign st_item[0] = head_item;
	assign st_rem[0]  = head_item.numer;
	assign st_quo[0]  = '0;
	assign st_vld[0]  = head_vld;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DIV_W-1:0] dsh;
		logic [DIV_W-1:0] diff;
		logic             take;

		assign dsh  = DIV_W'(st_item[k].samp_freq) << (QUO_W - 1 - k);
		assign diff = DIV_W'(st_rem[k]) - dsh;
		assign take = !diff[DIV_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= st_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				item_s[k] <= st_item[k];
				rem_s[k]  <= take ? diff[NUM_W-1:0] : st_rem[k];
				quo_s[k]  <= {st_quo[k][QUO_W-2:0], take};
			end
		end

		assign st_item[k+1] = item_s[k];
		assign st_rem[k+1]  = rem_s[k];
		assign st_quo[k+1]  = quo_s[k];
		assign st_vld[k+1]  = vld_s[k];
	end

	always_comb begin
		len_sum = {1'b0, st_quo[DIV_STAGES]} + (LEN_W + 1)'(st_item[DIV_STAGES].padding);
		if (st_item[DIV_STAGES].status != ST_OK) begin
			len_val = '0;
		end else if (st_item[DIV_STAGES].layer == LAYER_1) begin
			len_val = {len_sum[LEN_W-3:0], 2'b00};
		end else begin
			len_val = len_sum[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= st_vld[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q <= st_item[DIV_STAGES];
			out_len_q  <= len_val;
		end
	end

	assign out_vld  = out_vld_q;
	assign out_item = out_item_q;
	assign out_len  = out_len_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives audio frame header words into the decoder under changing sender and
// receiver idling, predicts every decoded beat and checks it field by field.
// ---------------------------------------------------------------------------
module testbench
	import mahd_pkg::*;
();

	localparam logic [10:0] HDR_SYNC = 11'h7FF;

	// version id codes as they appear in the header
	localparam logic [1:0] VID_25  = 2'd0;
	localparam logic [1:0] VID_RSV = 2'd1;
	localparam logic [1:0] VID_2   = 2'd2;
	localparam logic [1:0] VID_1   = 2'd3;

	// layer codes as they appear in the header
	localparam logic [1:0] LID_RSV = 2'd0;
	localparam logic [1:0] LID_3   = 2'd1;
	localparam logic [1:0] LID_2   = 2'd2;
	localparam logic [1:0] LID_1   = 2'd3;

	// decoded version and layer
	localparam logic [1:0] MPEG_1  = 2'd0;
	localparam logic [1:0] MPEG_2  = 2'd1;
	localparam logic [1:0] MPEG_25 = 2'd2;
	localparam logic [1:0] LAYER_I   = 2'd0;
	localparam logic [1:0] LAYER_II  = 2'd1;
	localparam logic [1:0] LAYER_III = 2'd2;

	localparam logic [3:0] KBPS_FREE = 4'd0;
	localparam logic [3:0] KBPS_BAD  = 4'd15;
	localparam logic [1:0] RATE_RSV  = 2'd3;

	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		status_t          status;
		logic [1:0]       version;
		logic [1:0]       layer;
		logic [BR_W-1:0]  kbps;
		logic [SR_W-1:0]  rate;
		logic             pad;
		logic             crc;
		logic [1:0]       chan;
		logic [1:0]       mext;
		logic [LEN_W-1:0] len;
	} hdr_result_t;

	int unsigned kbps_v1_l1 [16] = '{0, 32, 64, 96, 128, 160, 192, 224,
		256, 288, 320, 352, 384, 416, 448, 0};
	int unsigned kbps_v1_l2 [16] = '{0, 32, 48, 56, 64, 80, 96, 112,
		128, 160, 192, 224, 256, 320, 384, 0};
	int unsigned kbps_v1_l3 [16] = '{0, 32, 40, 48, 56, 64, 80, 96,
		112, 128, 160, 192, 224, 256, 320, 0};
	int unsigned kbps_lsf_l1 [16] = '{0, 32, 48, 56, 64, 80, 96, 112,
		128, 144, 160, 176, 192, 224, 256, 0};
	int unsigned kbps_lsf_l23 [16] = '{0, 8, 16, 24, 32, 40, 48, 56,
		64, 80, 96, 112, 128, 144, 160, 0};
	int unsigned rate_base [4] = '{44100, 48000, 32000, 0};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [31:0]          header_word = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           status;
	logic [1:0]           version;
	logic [1:0]           layer;
	logic [BR_W-1:0]      bitrate_kbps;
	logic [SR_W-1:0]      samp_freq_hz;
	logic                 padding;
	logic                 crc_flag;
	logic [1:0]           chan_mode;
	logic [1:0]           mode_extension;
	logic [LEN_W-1:0]     frame_length_bytes;

	logic [31:0]          pending_hdr [$];
	hdr_result_t          expected_dec [$];
	logic                 in_taken = 1'b0;
	logic                 recv_hold = 1'b0;
	logic                 hold_go = 1'b0;
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   n_queued = 0;
	int                   n_accepted = 0;
	int                   n_errors = 0;

	mpeg_audio_header_decode u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.header_word        (header_word),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.version            (version),
		.layer              (layer),
		.bitrate_kbps       (bitrate_kbps),
		.samp_freq_hz       (samp_freq_hz),
		.padding            (padding),
		.crc_flag           (crc_flag),
		.chan_mode          (chan_mode),
		.mode_extension     (mode_extension),
		.frame_length_bytes (frame_length_bytes)
	);

	always #5 clk = ~clk;

	function automatic hdr_result_t decode_header(logic [31:0] w);
		hdr_result_t r;
		logic [1:0]  ver;
		logic [1:0]  lay;
		logic [3:0]  bri;
		int unsigned br;
		int unsigned sr;
		int unsigned len;
		r = '0;
		r.status = ST_OK;
		if (w[31:21] != HDR_SYNC) begin
			r.status = ST_NOSYNC;
			return r;
		end
		bri = w[15:12];
		if (bri == KBPS_FREE || bri == KBPS_BAD || w[20:19] == VID_RSV ||
				w[18:17] == LID_RSV) begin
			r.status = ST_BADHDR;
			return r;
		end
		case (w[20:19])
			VID_1:   ver = MPEG_1;
			VID_2:   ver = MPEG_2;
			default: ver = MPEG_25;
		endcase
		case (w[18:17])
			LID_1:   lay = LAYER_I;
			LID_2:   lay = LAYER_II;
			default: lay = LAYER_III;
		endcase
		if (ver == MPEG_1) begin
			case (lay)
				LAYER_I:  br = kbps_v1_l1[bri];
				LAYER_II: br = kbps_v1_l2[bri];
				default:  br = kbps_v1_l3[bri];
			endcase
		end else if (lay == LAYER_I) begin
			br = kbps_lsf_l1[bri];
		end else begin
			br = kbps_lsf_l23[bri];
		end
		// lower sampling families halve the rate per step
		sr = rate_base[w[11:10]] >> ver;
		len = 0;
		if (sr != 0) begin
			if (lay == LAYER_I)
				len = ((12 * br * 1000) / sr + w[9]) * 4;
			else if (lay == LAYER_III && ver != MPEG_1)
				len = (72 * br * 1000) / sr + w[9];
			else
				len = (144 * br * 1000) / sr + w[9];
		end
		r.status  = (sr == 0) ? ST_RSVRATE : ST_OK;
		r.version = ver;
		r.layer   = lay;
		r.kbps    = br[BR_W-1:0];
		r.rate    = sr[SR_W-1:0];
		r.pad     = w[9];
		r.crc     = w[16];
		r.chan    = w[7:6];
		r.mext    = w[5:4];
		r.len     = len[LEN_W-1:0];
		return r;
	endfunction

	function automatic logic [31:0] build_header(logic [1:0] vid, logic [1:0] lid,
			logic prot, logic [3:0] bri, logic [1:0] sfc, logic pad, logic [7:0] low);
		return {HDR_SYNC, vid, lid, prot, bri, sfc, pad, low[7:0], 1'b0} |
			{23'd0, low[0], 8'd0} ^ {23'd0, 1'b0, 8'd0};
	endfunction

	function automatic logic [31:0] random_header();
		int          pick;
		logic [1:0]  vid;
		logic [1:0]  lid;
		logic [3:0]  bri;
		logic [1:0]  sfc;
		logic [31:0] w;
		pick = $urandom_range(99);
		case ($urandom_range(2))
			0:       vid = VID_1;
			1:       vid = VID_2;
			default: vid = VID_25;
		endcase
		case ($urandom_range(2))
			0:       lid = LID_1;
			1:       lid = LID_2;
			default: lid = LID_3;
		endcase
		bri = 4'($urandom_range(14, 1));
		sfc = ($urandom_range(9) == 0) ? RATE_RSV : 2'($urandom_range(2));
		w = $urandom;
		w[31:21] = HDR_SYNC;
		w[20:19] = vid;
		w[18:17] = lid;
		w[15:12] = bri;
		w[11:10] = sfc;
		if (pick >= 98) begin
			w = $urandom;
		end else if (pick >= 90) begin
			w[21 + $urandom_range(10)] = 1'b0;
		end else if (pick >= 78) begin
			case ($urandom_range(3))
				0:       w[15:12] = KBPS_FREE;
				1:       w[15:12] = KBPS_BAD;
				2:       w[20:19] = VID_RSV;
				default: w[18:17] = LID_RSV;
			endcase
		end
		return w;
	endfunction

	task automatic report_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			n_errors++;
			$display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic queue_random(int count);
		repeat (count) begin
			pending_hdr.push_back(random_header());
			n_queued++;
		end
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || expected_dec.size() != 0)
			@(posedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_hdr.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				header_word <= pending_hdr.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		out_ready <= arst_n && !recv_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// long receiver hold-off so the decoder backs up into its input
	initial begin
		wait (hold_go);
		@(negedge clk);
		recv_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		recv_hold <= 1'b0;
	end

	// input beats feed the predictor, output beats are checked against it
	always @(posedge clk) begin
		hdr_result_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_dec.push_back(decode_header(header_word));
				n_accepted++;
			end
			if (out_valid && out_ready) begin
				if (expected_dec.size() == 0) begin
					n_errors++;
					$display("%0t unexpected result beat: status %0d, length %0d",
						$time, status, frame_length_bytes);
				end else begin
					want = expected_dec.pop_front();
					report_field("status", want.status, status);
					report_field("version", want.version, version);
					report_field("layer", want.layer, layer);
					report_field("bitrate_kbps", want.kbps, bitrate_kbps);
					report_field("samp_freq_hz", want.rate, samp_freq_hz);
					report_field("padding", want.pad, padding);
					report_field("crc_flag", want.crc, crc_flag);
					report_field("chan_mode", want.chan, chan_mode);
					report_field("mode_extension", want.mext, mode_extension);
					report_field("frame_length_bytes", want.len, frame_length_bytes);
				end
			end
		end
	end

	initial begin
		logic [31:0] directed [$];
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sync missing
		directed.push_back(32'h0000_0000);
		directed.push_back(32'hFFDF_FFFF);
		directed.push_back(32'h7FFF_FFFF);
		// bad bitrate index, reserved version, reserved layer
		directed.push_back(32'hFFFF_FFFF);
		directed.push_back(build_header(VID_1, LID_3, 1'b1, KBPS_FREE, 2'd0, 1'b0, 8'h00));
		directed.push_back(build_header(VID_RSV, LID_2, 1'b0, 4'd9, 2'd1, 1'b1, 8'h55));
		directed.push_back(build_header(VID_2, LID_RSV, 1'b1, 4'd5, 2'd0, 1'b0, 8'hAA));
		// reserved sample rate
		directed.push_back(build_header(VID_1, LID_3, 1'b0, 4'd9, RATE_RSV, 1'b1, 8'h3C));
		directed.push_back(build_header(VID_25, LID_3, 1'b1, 4'd14, RATE_RSV, 1'b0, 8'hF0));
		directed.push_back(build_header(VID_2, LID_1, 1'b1, 4'd1, RATE_RSV, 1'b1, 8'h0F));
		// every version and layer at the bitrate and rate extremes
		directed.push_back(build_header(VID_1, LID_1, 1'b1, 4'd14, 2'd2, 1'b1, 8'h00));
		directed.push_back(build_header(VID_1, LID_2, 1'b1, 4'd14, 2'd2, 1'b1, 8'h00));
		directed.push_back(build_header(VID_1, LID_3, 1'b0, 4'd14, 2'd2, 1'b1, 8'hFF));
		directed.push_back(build_header(VID_1, LID_3, 1'b1, 4'd1, 2'd1, 1'b0, 8'h00));
		directed.push_back(build_header(VID_2, LID_1, 1'b0, 4'd14, 2'd2, 1'b0, 8'h12));
		directed.push_back(build_header(VID_2, LID_2, 1'b1, 4'd14, 2'd2, 1'b1, 8'h34));
		directed.push_back(build_header(VID_2, LID_3, 1'b0, 4'd14, 2'd2, 1'b1, 8'h56));
		directed.push_back(build_header(VID_25, LID_1, 1'b1, 4'd14, 2'd2, 1'b1, 8'h78));
		directed.push_back(build_header(VID_25, LID_2, 1'b0, 4'd14, 2'd2, 1'b0, 8'h9A));
		directed.push_back(build_header(VID_25, LID_3, 1'b1, 4'd1, 2'd1, 1'b0, 8'hBC));
		// low header bits all set, then all clear
		directed.push_back(build_header(VID_1, LID_2, 1'b1, 4'd1, 2'd0, 1'b0, 8'hFF) | 32'h1FF);
		directed.push_back(build_header(VID_1, LID_2, 1'b0, 4'd1, 2'd0, 1'b0, 8'h00));
		foreach (directed[i]) begin
			pending_hdr.push_back(directed[i]);
			n_queued++;
		end
		wait_drained();

		// no idling, with the long receiver hold-off on top
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(125);
		hold_go = 1'b1;
		wait_drained();

		send_idle_pct = 65;
		recv_stall_pct = 0;
		queue_random(125);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 65;
		queue_random(125);
		wait_drained();

		send_idle_pct = 32;
		recv_stall_pct = 32;
		queue_random(125);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && expected_dec.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
